[rtl/tcq_pkg.sv]
// Package for the two-class ticket queue with expiry.
// Holds the entry layout, operation, status and sequencer codes, and the ranking function.
// No dependencies.
package tcq_pkg;

  localparam int DEF_QUEUE_DEPTH = 64;
  localparam int DEF_MAX_WINDOWS = 16;
  localparam int SEC_PER_MIN     = 60;
  localparam int TIMEOUT_RESET   = 30;
  localparam int QLIMIT_RESET    = 64;
  localparam int WINDOWS_RESET   = 8;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ISSUE   = 3'd1,
    OP_SERVE   = 3'd2,
    OP_POSN    = 3'd3,
    OP_PROMOTE = 3'd4,
    OP_CANCEL  = 3'd5,
    OP_EXPIRE  = 3'd6,
    OP_RELEASE = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_WIN   = 3'd2,
    ST_WIN_BUSY  = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR  = 2'd0,
    S_IDLE   = 2'd1,
    S_SCAN   = 2'd2,
    S_RANK   = 2'd3
  } seq_t;

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_QLIMIT  = 2'd1,
    CFG_WINDOWS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        valid;
    logic        prio;
    logic [30:0] ticket;
    logic [31:0] stamp;
    logic [31:0] order;
  } entry_t;

  // True when entry a is served before entry b
  function automatic logic rank_before(entry_t a, entry_t b, logic [31:0] now);
    logic [31:0] age_a;
    logic [31:0] age_b;
    age_a = now - a.stamp;
    age_b = now - b.stamp;
    if (a.prio != b.prio) return a.prio;
    if (age_a != age_b) return age_a > age_b;
    return a.order < b.order;
  endfunction

endpackage

[rtl/two_class_ticket_queue_with_expiry_core.sv]
// Top level of the two-class ticket queue with expiry.
// One entry memory, a scan sequencer and an output register; uses tcq_pkg.
//
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_stall   | op, customer_vip, window_number, ticket_id
// out     | out | out_valid/out_stall | status, result_ticket, result_vip, position, counts
// cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// Tick and release finish without a scan; issue, serve, expire, promote and cancel take one
// scan of the entry memory; position takes a second scan to rank a found ticket.
// The one-read-port entry memory sets this pattern.
// After reset a clearing pass over the entry memory runs with in_stall high.
// A request waits in the last cycle while a previous result is stalled on the output.
module two_class_ticket_queue_with_expiry_core
  import tcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int MAX_WINDOWS = DEF_MAX_WINDOWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  op,
  input  logic        customer_vip,
  input  logic [4:0]  window_number,
  input  logic [30:0] ticket_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [30:0] result_ticket,
  output logic        result_vip,
  output logic [6:0]  position,
  output logic [6:0]  priority_count,
  output logic [6:0]  normal_count,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int LW = (CW > 7) ? CW : 7;
  localparam int WW = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;

  // Configuration registers
  logic [9:0] timeout_minutes;
  logic [6:0] queue_limit;
  logic [4:0] window_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_minutes <= 10'(TIMEOUT_RESET);
      queue_limit     <= 7'(QLIMIT_RESET);
      window_count    <= 5'(WINDOWS_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_minutes <= cfg_data;
        CFG_QLIMIT:  queue_limit     <= cfg_data[6:0];
        CFG_WINDOWS: window_count    <= cfg_data[4:0];
        default:     ;
      endcase
    end
  end

  // Entry memory
  entry_t          mem [QUEUE_DEPTH];
  entry_t          rd_e;
  logic [AW-1:0]   raddr;
  logic            mem_we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rd_e <= mem[raddr];
  end

  // Sequencer and held request
  seq_t            state, state_next;
  logic [CW-1:0]   cnt;
  logic            p_vld;
  logic [AW-1:0]   p_idx;
  op_t             op_r;
  logic            vip_r;
  logic [4:0]      win_r;
  logic [30:0]     tid_r;
  logic [31:0]     now_seconds;
  logic [30:0]     next_ticket;
  logic [MAX_WINDOWS-1:0] window_busy;
  logic [CW-1:0]   pcnt, ncnt;
  entry_t          held;
  logic [AW-1:0]   held_idx;
  logic            held_found;
  logic [AW-1:0]   free_idx;
  logic            free_found;
  logic [CW-1:0]   pos;

  logic            accept, cnt_end, finish, go;
  logic [15:0]     tmo_secs;
  logic [31:0]     age;
  logic            do_exp, expd, live, take;
  logic [LW:0]     tot_x, qlim_x, dep_x, lim_x;
  logic [6:0]      wl;
  logic            win_ok;
  logic [WW-1:0]   win_idx;
  logic [2:0]      st_v;
  logic [30:0]     rt_v;
  logic            rv_v;
  logic [CW-1:0]   pc_v, nc_v;
  logic            busy_set, busy_clr, tick_v, issue_v;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign cnt_end  = (cnt == CW'(QUEUE_DEPTH));
  assign go       = !out_valid || !out_stall;
  assign raddr    = cnt[AW-1:0];

  // Scan element decode
  assign tmo_secs = 16'(timeout_minutes * SEC_PER_MIN);
  assign age      = now_seconds - rd_e.stamp;
  assign do_exp   = (op_r == OP_ISSUE) || (op_r == OP_SERVE) || (op_r == OP_EXPIRE);
  assign expd     = p_vld && do_exp && rd_e.valid && (age > {16'b0, tmo_secs});
  assign live     = p_vld && rd_e.valid && !expd;
  always_comb begin
    take = 1'b0;
    case (op_r)
      OP_SERVE: take = live && (!held_found || rank_before(rd_e, held, now_seconds));
      OP_POSN, OP_PROMOTE, OP_CANCEL:
        take = live && !held_found && (rd_e.ticket == tid_r);
      default:  take = 1'b0;
    endcase
  end

  // Limits
  assign tot_x  = (LW+1)'(pcnt) + (LW+1)'(ncnt);
  assign qlim_x = (LW+1)'(queue_limit);
  assign dep_x  = (LW+1)'(QUEUE_DEPTH);
  assign lim_x  = (qlim_x < dep_x) ? qlim_x : dep_x;
  assign wl     = (7'(window_count) < 7'(MAX_WINDOWS)) ? 7'(window_count) : 7'(MAX_WINDOWS);
  assign win_ok = (win_r != 5'd0) && (7'(win_r) <= wl);
  assign win_idx = WW'(win_r - 5'd1);

  // Next state, memory write and end-of-request outcome
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    waddr      = p_idx;
    wdata      = rd_e;
    finish     = 1'b0;
    st_v       = ST_OK;
    rt_v       = '0;
    rv_v       = 1'b0;
    pc_v       = pcnt;
    nc_v       = ncnt;
    busy_set   = 1'b0;
    busy_clr   = 1'b0;
    tick_v     = 1'b0;
    issue_v    = 1'b0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        waddr  = cnt[AW-1:0];
        wdata  = '0;
        if (cnt == CW'(QUEUE_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (expd) begin
          mem_we      = 1'b1;
          wdata.valid = 1'b0;
          if (rd_e.prio) pc_v = pcnt - 1'b1;
          else nc_v = ncnt - 1'b1;
        end
        // Rank a found ticket once the last read has landed
        if (cnt_end && !p_vld && op_r == OP_POSN && held_found) state_next = S_RANK;
        // Final outcome once the scan is over; no scan for tick and release
        if ((op_r == OP_TICK) || (op_r == OP_RELEASE) ||
            (cnt_end && !p_vld && !(op_r == OP_POSN && held_found))) begin
          state_next = S_SCAN;
          finish     = go;
          if (go) state_next = S_IDLE;
        end
        if (finish) begin
          unique case (op_r)
            OP_TICK: tick_v = 1'b1;
            OP_ISSUE: begin
              if (tot_x >= lim_x || !free_found) st_v = ST_FULL;
              else begin
                mem_we       = 1'b1;
                waddr        = free_idx;
                wdata.valid  = 1'b1;
                wdata.prio   = vip_r;
                wdata.ticket = next_ticket;
                wdata.stamp  = now_seconds;
                wdata.order  = {1'b0, next_ticket};
                rt_v         = next_ticket;
                rv_v         = vip_r;
                issue_v      = 1'b1;
                if (vip_r) pc_v = pcnt + 1'b1;
                else nc_v = ncnt + 1'b1;
              end
            end
            OP_SERVE: begin
              if (!win_ok) st_v = ST_BAD_WIN;
              else if (window_busy[win_idx]) st_v = ST_WIN_BUSY;
              else if (!held_found) st_v = ST_EMPTY;
              else begin
                mem_we      = 1'b1;
                waddr       = held_idx;
                wdata       = held;
                wdata.valid = 1'b0;
                rt_v        = held.ticket;
                rv_v        = held.prio;
                busy_set    = 1'b1;
                if (held.prio) pc_v = pcnt - 1'b1;
                else nc_v = ncnt - 1'b1;
              end
            end
            OP_POSN: st_v = held_found ? ST_OK : ST_NOT_FOUND;
            OP_PROMOTE: begin
              if (!held_found || held.prio) st_v = ST_NOT_FOUND;
              else begin
                mem_we     = 1'b1;
                waddr      = held_idx;
                wdata      = held;
                wdata.prio = 1'b1;
                pc_v       = pcnt + 1'b1;
                nc_v       = ncnt - 1'b1;
              end
            end
            OP_CANCEL: begin
              if (!held_found) st_v = ST_NOT_FOUND;
              else begin
                mem_we      = 1'b1;
                waddr       = held_idx;
                wdata       = held;
                wdata.valid = 1'b0;
                if (held.prio) pc_v = pcnt - 1'b1;
                else nc_v = ncnt - 1'b1;
              end
            end
            OP_EXPIRE: st_v = ST_OK;
            OP_RELEASE: begin
              if (!win_ok) st_v = ST_BAD_WIN;
              else busy_clr = 1'b1;
            end
          endcase
        end
      end
      S_RANK: begin
        if (cnt_end && !p_vld) begin
          finish = go;
          st_v   = ST_OK;
          if (go) state_next = S_IDLE;
        end
      end
    endcase
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // Scan counter and read pipeline; a scan ends in the cycle after the last read lands
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      p_vld <= 1'b0;
    end else begin
      p_vld <= 1'b0;
      if (state == S_CLEAR) begin
        cnt <= (cnt == CW'(QUEUE_DEPTH - 1)) ? '0 : cnt + 1'b1;
      end else if (state == S_IDLE) begin
        cnt <= '0;
      end else if (state_next != state) begin
        cnt <= '0;
      end else if (!cnt_end) begin
        cnt   <= cnt + 1'b1;
        p_vld <= 1'b1;
      end
      p_idx <= cnt[AW-1:0];
    end
  end

  // Hold the request and scan results
  always_ff @(posedge clk) begin
    if (rst) begin
      held_found <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      op_r       <= op_t'(op);
      vip_r      <= customer_vip;
      win_r      <= window_number;
      tid_r      <= ticket_id;
      held_found <= 1'b0;
      free_found <= 1'b0;
      pos        <= CW'(1);
    end else if (state == S_SCAN) begin
      if (take) begin
        held       <= rd_e;
        held_idx   <= p_idx;
        held_found <= 1'b1;
      end
      if (p_vld && !live && !free_found) begin
        free_idx   <= p_idx;
        free_found <= 1'b1;
      end
    end else if (state == S_RANK) begin
      if (p_vld && rd_e.valid && p_idx != held_idx && rank_before(rd_e, held, now_seconds))
        pos <= pos + 1'b1;
    end
  end

  // Time, ticket numbering, windows and class counts
  always_ff @(posedge clk) begin
    if (rst) begin
      now_seconds <= '0;
      next_ticket <= 31'd1;
      window_busy <= '0;
      pcnt        <= '0;
      ncnt        <= '0;
    end else begin
      pcnt <= pc_v;
      ncnt <= nc_v;
      if (tick_v) now_seconds <= now_seconds + 32'd1;
      if (issue_v) next_ticket <= (next_ticket == 31'h7FFF_FFFF) ? 31'd1 : next_ticket + 31'd1;
      if (busy_set) window_busy[win_idx] <= 1'b1;
      if (busy_clr) window_busy[win_idx] <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (finish) begin
        out_valid      <= 1'b1;
        status         <= st_v;
        result_ticket  <= rt_v;
        result_vip     <= rv_v;
        position       <= (op_r == OP_POSN && held_found) ? 7'(pos) : 7'd0;
        priority_count <= 7'(pc_v);
        normal_count   <= 7'(nc_v);
      end
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(pcnt) + (CW+1)'(ncnt) <= (CW+1)'(QUEUE_DEPTH))
    else $error("class counts exceed queue depth");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall)
    else $error("request taken while another is in progress");

  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_SCAN && !finish) |-> p_vld)
    else $error("entry write without a scanned entry");

endmodule
